@@ hdl/return_watch_stack_unit_macros.svh @@
// assertion macros shared by the return watch stack checker
`ifndef RETURN_WATCH_STACK_UNIT_MACROS_SVH
`define RETURN_WATCH_STACK_UNIT_MACROS_SVH

// same-cycle implication, sampled on clk, off during reset
`define RWSU_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("return watch stack check failed");

// next-cycle implication, sampled on clk, off during reset
`define RWSU_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("return watch stack check failed");

`endif

@@ hdl/rwsu_pkg.sv @@
// shared types and constants of the return watch stack
`timescale 1ns / 1ps

package rwsu_pkg;

  // default configuration
  localparam int WATCH_DEPTH_DEF = 256;
  localparam int CPU_COUNT_DEF   = 2;

  // item operation codes
  localparam logic OP_PUSH  = 1'b0;
  localparam logic OP_CHECK = 1'b1;

  // result field widths
  localparam int DEPTH_OUT_W = 9;

  // clears the thumb tag of a return key
  localparam logic [31:0] KEY_TAG_MASK = 32'hFFFF_FFFE;

  // one stored watch
  typedef struct packed {
    logic [15:0] slot;
    logic [31:0] key;
    logic [31:0] sp;
  } watch_entry_t;

  localparam int ENTRY_W = $bits(watch_entry_t);

endpackage

@@ hdl/rwsu_ram.sv @@
// generic simple dual-port ram with registered read data
`timescale 1ns / 1ps

module rwsu_ram #(
  parameter int WIDTH = rwsu_pkg::ENTRY_W,
  parameter int DEPTH = rwsu_pkg::WATCH_DEPTH_DEF * rwsu_pkg::CPU_COUNT_DEF,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // one write and one registered read per cycle
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ hdl/return_watch_stack_unit.sv @@
// return watch stack: per-cpu bounded stacks of pending return watches
`timescale 1ns / 1ps

// Keeps one stack of up to WATCH_DEPTH return watches for each of CPU_COUNT
// CPUs in a single entry ram (CPU_COUNT * WATCH_DEPTH words, one read and one
// write port, registered read data). One item is worked on at a time and
// every step walks the ram one entry per cycle. A push to a stack that is not
// full goes from acceptance through S_PUT and S_DONE to its result; a push to
// a full stack drops the oldest watch by moving the other WATCH_DEPTH-1
// entries down. A check reads from the top one entry per cycle until a watch
// with equal key and stack pointer turns up or the bottom is passed, then
// closes the gap by moving every entry above it down one place. The next
// item is taken while a finished result still waits in the output register.
// After reset the ram holds nothing valid; stacks start empty and need no
// clearing pass.
module return_watch_stack_unit #(
  parameter int WATCH_DEPTH = rwsu_pkg::WATCH_DEPTH_DEF,
  parameter int CPU_COUNT   = rwsu_pkg::CPU_COUNT_DEF
) (
  input  logic        clk,
  input  logic        rst,
  // input items
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        operation,
  input  logic        cpu_index,
  input  logic [15:0] slot_id,
  input  logic [31:0] return_address,
  input  logic [31:0] stack_ptr,
  input  logic        thumb_mode,
  // result items
  output logic        out_valid,
  input  logic        out_ready,
  output logic        matched,
  output logic [15:0] matched_slot,
  output logic [31:0] matched_return,
  output logic [31:0] matched_sp,
  output logic        evicted,
  output logic        armed,
  output logic [rwsu_pkg::DEPTH_OUT_W-1:0] depth_now
);

  localparam int TOTAL = CPU_COUNT * WATCH_DEPTH;
  localparam int AW    = $clog2(TOTAL);
  localparam int IW    = $clog2(WATCH_DEPTH);
  localparam int DW    = $clog2(WATCH_DEPTH + 1);
  localparam int CW    = (CPU_COUNT > 1) ? $clog2(CPU_COUNT) : 1;
  localparam logic [DW-1:0] FULL = DW'(WATCH_DEPTH);

  // sequencer states
  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_SEARCH = 3'd1;
  localparam logic [2:0] S_SHIFT  = 3'd2;
  localparam logic [2:0] S_PUT    = 3'd3;
  localparam logic [2:0] S_DONE   = 3'd4;

  logic [2:0]    state;
  logic [DW-1:0] stack_depth [CPU_COUNT];

  // item registers
  logic [CW-1:0] cpu_r;
  logic [15:0]   slot_r;
  logic [31:0]   key_r;
  logic [31:0]   sp_r;
  logic [AW-1:0] base_r;
  logic [DW-1:0] depth_r;
  logic [DW-1:0] shift_end;
  logic [IW-1:0] idx;
  logic          evict_r;
  logic          bad_r;
  logic          hit_r;
  logic [15:0]   hit_slot;
  logic [31:0]   hit_ret;
  logic [31:0]   hit_sp;

  // ram ports
  logic                          ram_we;
  logic [AW-1:0]                 ram_waddr;
  logic [AW-1:0]                 ram_raddr;
  logic [rwsu_pkg::ENTRY_W-1:0]  ram_rdata;
  rwsu_pkg::watch_entry_t        ram_wentry;
  rwsu_pkg::watch_entry_t        rd_entry;

  logic          accept;
  logic          cpu_ok;
  logic [DW-1:0] sel_depth;
  logic [AW-1:0] in_base;
  logic [31:0]   in_key;
  logic          hit;
  logic          more_above;
  logic          more_shift;
  logic          out_free;

  assign in_ready = (state == S_IDLE);
  assign accept   = in_valid && in_ready;
  assign out_free = !out_valid || out_ready;
  assign cpu_ok   = int'(cpu_index) < CPU_COUNT;
  assign in_base  = AW'(cpu_index) * AW'(WATCH_DEPTH);
  assign in_key   = {return_address[31:1], thumb_mode};
  assign rd_entry = ram_rdata;

  // entry just read matches the key and stack pointer of the check
  assign hit        = (rd_entry.key == key_r) && (rd_entry.sp == sp_r);
  assign more_above = (DW'(idx) + 1'b1) < depth_r;
  assign more_shift = (DW'(idx) + 1'b1) < shift_end;

  // depth of the addressed cpu's stack
  always_comb begin
    sel_depth = '0;
    for (int c = 0; c < CPU_COUNT; c++) begin
      if (int'(cpu_index) == c) begin
        sel_depth = stack_depth[c];
      end
    end
  end

  // ram addressing per state
  always_comb begin
    ram_raddr  = '0;
    ram_we     = 1'b0;
    ram_waddr  = '0;
    ram_wentry = rd_entry;
    case (state)
      S_IDLE: begin
        if (operation == rwsu_pkg::OP_PUSH) begin
          ram_raddr = in_base + AW'(1);
        end else begin
          ram_raddr = in_base + AW'(sel_depth - 1'b1);
        end
      end
      S_SEARCH: begin
        if (hit) begin
          ram_raddr = base_r + AW'(DW'(idx) + 1'b1);
        end else begin
          ram_raddr = base_r + AW'(idx - 1'b1);
        end
      end
      S_SHIFT: begin
        ram_raddr = base_r + AW'(DW'(idx) + 1'b1);
        ram_we    = 1'b1;
        ram_waddr = base_r + AW'(idx - 1'b1);
      end
      S_PUT: begin
        ram_we     = 1'b1;
        ram_waddr  = base_r + AW'(depth_r);
        ram_wentry = '{slot: slot_r, key: key_r, sp: sp_r};
      end
      default: begin
        ram_raddr = '0;
      end
    endcase
  end

  rwsu_ram #(
    .WIDTH (rwsu_pkg::ENTRY_W),
    .DEPTH (TOTAL),
    .AW    (AW)
  ) u_entries (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wentry),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // sequencer and per-cpu depths
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      for (int c = 0; c < CPU_COUNT; c++) begin
        stack_depth[c] <= '0;
      end
    end else begin
      case (state)
        S_IDLE: begin
          if (accept) begin
            if (!cpu_ok) begin
              state <= S_DONE;
            end else if (operation == rwsu_pkg::OP_PUSH) begin
              state <= (sel_depth == FULL) ? S_SHIFT : S_PUT;
            end else begin
              state <= (sel_depth == '0) ? S_DONE : S_SEARCH;
            end
          end
        end
        S_SEARCH: begin
          if (hit) begin
            state <= more_above ? S_SHIFT : S_DONE;
          end else if (idx == '0) begin
            state <= S_DONE;
          end
        end
        S_SHIFT: begin
          if (!more_shift) begin
            state <= evict_r ? S_PUT : S_DONE;
          end
        end
        S_PUT: begin
          state <= S_DONE;
        end
        S_DONE: begin
          if (out_free) begin
            state <= S_IDLE;
            for (int c = 0; c < CPU_COUNT; c++) begin
              if (!bad_r && (int'(cpu_r) == c)) begin
                stack_depth[c] <= depth_r;
              end
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // item datapath registers
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        if (accept) begin
          cpu_r    <= CW'(cpu_index);
          slot_r   <= slot_id;
          sp_r     <= stack_ptr;
          key_r    <= (operation == rwsu_pkg::OP_CHECK) ? in_key : return_address;
          base_r   <= in_base;
          depth_r  <= cpu_ok ? sel_depth : '0;
          bad_r    <= !cpu_ok;
          evict_r  <= (operation == rwsu_pkg::OP_PUSH) && (sel_depth == FULL);
          hit_r    <= 1'b0;
          hit_slot <= '0;
          hit_ret  <= '0;
          hit_sp   <= '0;
          shift_end <= FULL;
          idx      <= (operation == rwsu_pkg::OP_PUSH) ? IW'(1) : IW'(sel_depth - 1'b1);
        end
      end
      S_SEARCH: begin
        if (hit) begin
          hit_r     <= 1'b1;
          hit_slot  <= rd_entry.slot;
          hit_ret   <= rd_entry.key & rwsu_pkg::KEY_TAG_MASK;
          hit_sp    <= rd_entry.sp;
          shift_end <= depth_r;
          if (more_above) begin
            idx <= idx + 1'b1;
          end else begin
            depth_r <= depth_r - 1'b1;
          end
        end else if (idx != '0) begin
          idx <= idx - 1'b1;
        end
      end
      S_SHIFT: begin
        if (more_shift) begin
          idx <= idx + 1'b1;
        end else begin
          depth_r <= depth_r - 1'b1;
        end
      end
      S_PUT: begin
        depth_r <= depth_r + 1'b1;
      end
      default: begin
        idx <= idx;
      end
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= ((state == S_DONE) && out_free) || (out_valid && !out_ready);
    end
  end

  always_ff @(posedge clk) begin
    if ((state == S_DONE) && out_free) begin
      matched        <= hit_r;
      matched_slot   <= hit_slot;
      matched_return <= hit_ret;
      matched_sp     <= hit_sp;
      evicted        <= evict_r;
      armed          <= depth_r != '0;
      depth_now      <= rwsu_pkg::DEPTH_OUT_W'(depth_r);
    end
  end

endmodule

@@ hdl/rwsu_checker.sv @@
// port-level checks of the return watch stack, bound to the top level
`timescale 1ns / 1ps
`include "return_watch_stack_unit_macros.svh"

module rwsu_checker (
  input logic        clk,
  input logic        rst,
  input logic        out_valid,
  input logic        out_ready,
  input logic        matched,
  input logic [15:0] matched_slot,
  input logic [31:0] matched_return,
  input logic [31:0] matched_sp,
  input logic        evicted,
  input logic        armed,
  input logic [rwsu_pkg::DEPTH_OUT_W-1:0] depth_now
);

  // a waiting result item holds
  `RWSU_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(matched_slot) && $stable(depth_now))

  // no match reports zero watch fields
  `RWSU_ASSERT_NOW(a_miss_zero, out_valid && !matched, matched_slot == 16'd0 && matched_return == 32'd0 && matched_sp == 32'd0)

  // a removed watch comes from a check, with its tag cleared
  `RWSU_ASSERT_NOW(a_hit_form, out_valid && matched, !evicted && !matched_return[0])

  // an empty stack reports no depth and no eviction
  `RWSU_ASSERT_NOW(a_unarmed, out_valid && !armed, depth_now == '0 && !evicted)

endmodule

bind return_watch_stack_unit rwsu_checker u_rwsu_checker (
  .clk            (clk),
  .rst            (rst),
  .out_valid      (out_valid),
  .out_ready      (out_ready),
  .matched        (matched),
  .matched_slot   (matched_slot),
  .matched_return (matched_return),
  .matched_sp     (matched_sp),
  .evicted        (evicted),
  .armed          (armed),
  .depth_now      (depth_now)
);

@@ sim/return_watch_stack_checker.sv @@
// checker that predicts and compares every result of the return watch stack
`timescale 1ns / 1ps

module return_watch_stack_checker
  import rwsu_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  input  logic                   in_ready,
  input  logic                   operation,
  input  logic                   cpu_index,
  input  logic [15:0]            slot_id,
  input  logic [31:0]            return_address,
  input  logic [31:0]            stack_ptr,
  input  logic                   thumb_mode,
  input  logic                   out_valid,
  input  logic                   out_ready,
  input  logic                   matched,
  input  logic [15:0]            matched_slot,
  input  logic [31:0]            matched_return,
  input  logic [31:0]            matched_sp,
  input  logic                   evicted,
  input  logic                   armed,
  input  logic [DEPTH_OUT_W-1:0] depth_now,
  output int                     fails,
  output int                     pending,
  output int                     hits,
  output int                     drops
);

  localparam int WATCHES = WATCH_DEPTH_DEF;
  localparam int CPUS    = CPU_COUNT_DEF;

  typedef struct packed {
    logic                   found;
    logic [15:0]            slot;
    logic [31:0]            ret;
    logic [31:0]            sp;
    logic                   dropped;
    logic                   armed;
    logic [DEPTH_OUT_W-1:0] depth;
  } return_result_t;

  // predicted contents of each cpu stack, bottom at index 0
  watch_entry_t   watch_stack [CPUS][WATCHES];
  int             watch_fill  [CPUS];
  return_result_t results_due [$];
  int             result_no;

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("result %0d: %s is %h, predicted %h", result_no, what, got, want);
    fails++;
  endtask

  // update the predicted stacks for one item and queue its result
  task automatic predict_watch(input logic op, input logic cpu, input logic [15:0] slot,
                               input logic [31:0] addr, input logic [31:0] sp,
                               input logic thumb);
    return_result_t r;
    logic [31:0]    key;
    int             n;
    int             hit;
    int             i;
    r = '0;
    n = watch_fill[cpu];
    if (op == OP_PUSH) begin
      // full stack: drop the oldest watch and shift the rest down
      if (n == WATCHES) begin
        for (i = 1; i < WATCHES; i++) watch_stack[cpu][i-1] = watch_stack[cpu][i];
        n--;
        r.dropped = 1'b1;
        drops++;
      end
      watch_stack[cpu][n].slot = slot;
      watch_stack[cpu][n].key  = addr;
      watch_stack[cpu][n].sp   = sp;
      n++;
    end else begin
      // search from the top for equal key and stack pointer
      key = {addr[31:1], thumb};
      hit = -1;
      for (i = n - 1; i >= 0 && hit < 0; i--) begin
        if (watch_stack[cpu][i].key == key && watch_stack[cpu][i].sp == sp) hit = i;
      end
      if (hit >= 0) begin
        r.found = 1'b1;
        r.slot  = watch_stack[cpu][hit].slot;
        r.ret   = watch_stack[cpu][hit].key & KEY_TAG_MASK;
        r.sp    = watch_stack[cpu][hit].sp;
        for (i = hit + 1; i < n; i++) watch_stack[cpu][i-1] = watch_stack[cpu][i];
        n--;
        hits++;
      end
    end
    watch_fill[cpu] = n;
    r.armed = (n != 0);
    r.depth = n[DEPTH_OUT_W-1:0];
    results_due.insert(results_due.size(), r);
  endtask

  // compare one result item with the oldest prediction
  task automatic compare_result();
    return_result_t want;
    result_no++;
    if (results_due.size() == 0) begin
      report_mismatch("result with nothing pending, depth_now", 32'(depth_now), '0);
    end else begin
      want = results_due.pop_front();
      if (matched !== want.found) report_mismatch("matched", 32'(matched), 32'(want.found));
      if (matched_slot !== want.slot)
        report_mismatch("matched_slot", 32'(matched_slot), 32'(want.slot));
      if (matched_return !== want.ret) report_mismatch("matched_return", matched_return, want.ret);
      if (matched_sp !== want.sp) report_mismatch("matched_sp", matched_sp, want.sp);
      if (evicted !== want.dropped)
        report_mismatch("evicted", 32'(evicted), 32'(want.dropped));
      if (armed !== want.armed) report_mismatch("armed", 32'(armed), 32'(want.armed));
      if (depth_now !== want.depth) report_mismatch("depth_now", 32'(depth_now), 32'(want.depth));
    end
  endtask

  // watch both channels at each rising edge
  always @(posedge clk) begin
    if (rst) begin
      results_due.delete();
      foreach (watch_fill[c]) watch_fill[c] = 0;
      fails     = 0;
      pending   = 0;
      hits      = 0;
      drops     = 0;
      result_no = 0;
    end else begin
      if (in_valid && in_ready)
        predict_watch(operation, cpu_index, slot_id, return_address, stack_ptr, thumb_mode);
      if (out_valid && out_ready) compare_result();
      pending = results_due.size();
    end
  end

endmodule

@@ sim/tb_return_watch_stack_unit.sv @@
// testbench top for the return watch stack: stimulus, idling and verdict
`timescale 1ns / 1ps

module tb_return_watch_stack_unit;
  import rwsu_pkg::*;

  localparam int WATCHES   = WATCH_DEPTH_DEF;
  localparam int QUIET_MAX = 5000;
  localparam int SETTLE    = 2 * WATCH_DEPTH_DEF + 20;

  typedef struct packed {
    logic [31:0] addr;
    logic [31:0] sp;
  } pushed_t;

  logic                   clk            = 1'b0;
  logic                   rst            = 1'b1;
  logic                   in_valid       = 1'b0;
  logic                   in_ready;
  logic                   operation      = OP_PUSH;
  logic                   cpu_index      = 1'b0;
  logic [15:0]            slot_id        = '0;
  logic [31:0]            return_address = '0;
  logic [31:0]            stack_ptr      = '0;
  logic                   thumb_mode     = 1'b0;
  logic                   out_valid;
  logic                   out_ready      = 1'b0;
  logic                   matched;
  logic [15:0]            matched_slot;
  logic [31:0]            matched_return;
  logic [31:0]            matched_sp;
  logic                   evicted;
  logic                   armed;
  logic [DEPTH_OUT_W-1:0] depth_now;

  int fails;
  int pending;
  int hits;
  int drops;
  int idle_pct     = 0;
  int stall_pct    = 0;
  int quiet_cycles = 0;
  int pushes_sent  = 0;
  int checks_sent  = 0;

  // watches pushed per cpu, used only to aim checks at live entries
  pushed_t shadow [2][$];

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  return_watch_stack_unit dut (.*);

  return_watch_stack_checker checker_i (.*);

  // receiver stalls
  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= stall_pct);
  end

  // watchdog on cycles without any accepted item or taken result
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_MAX) begin
      $display("return_watch_stack_unit regression: fail");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // offer one item, with an optional idle gap first, and wait for acceptance
  task automatic send_item(input logic op, input logic cpu, input logic [15:0] slot,
                           input logic [31:0] addr, input logic [31:0] sp,
                           input logic thumb);
    if (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < idle_pct);
    end
    in_valid       <= 1'b1;
    operation      <= op;
    cpu_index      <= cpu;
    slot_id        <= slot;
    return_address <= addr;
    stack_ptr      <= sp;
    thumb_mode     <= thumb;
    // ready only moves at rising edges, so look at it mid-cycle
    do @(negedge clk); while (!in_ready);
    @(posedge clk);
    if (op == OP_PUSH) pushes_sent++;
    else checks_sent++;
  endtask

  task automatic send_push(input logic cpu, input logic [15:0] slot,
                           input logic [31:0] addr, input logic [31:0] sp);
    pushed_t w;
    w.addr = addr;
    w.sp   = sp;
    shadow[cpu].insert(shadow[cpu].size(), w);
    if (shadow[cpu].size() > WATCHES) void'(shadow[cpu].pop_front());
    send_item(OP_PUSH, cpu, slot, addr, sp, 1'($urandom_range(1)));
  endtask

  // check that misses, or nearly hits a live watch
  task automatic check_noise(input logic cpu);
    pushed_t w;
    if (shadow[cpu].size() != 0 && $urandom_range(1) == 1) begin
      w = shadow[cpu][$urandom_range(shadow[cpu].size() - 1)];
      if ($urandom_range(1) == 1)
        send_item(OP_CHECK, cpu, 16'($urandom), w.addr, w.sp, ~w.addr[0]);
      else
        send_item(OP_CHECK, cpu, 16'($urandom), w.addr, w.sp ^ 32'h4, w.addr[0]);
    end else begin
      send_item(OP_CHECK, cpu, 16'($urandom), $urandom, $urandom, 1'($urandom_range(1)));
    end
  endtask

  // check aimed at a live watch, either the top one or anywhere in the stack
  task automatic check_known(input logic cpu);
    pushed_t w;
    int      k;
    if (shadow[cpu].size() == 0) begin
      check_noise(cpu);
    end else begin
      if ($urandom_range(1) == 1) k = shadow[cpu].size() - 1;
      else k = $urandom_range(shadow[cpu].size() - 1);
      w = shadow[cpu][k];
      shadow[cpu].delete(k);
      send_item(OP_CHECK, cpu, 16'($urandom), {w.addr[31:1], 1'($urandom_range(1))}, w.sp,
                w.addr[0]);
    end
  endtask

  task automatic random_item(input int push_pct, input int cpu1_pct);
    logic        cpu;
    logic [31:0] addr;
    logic [31:0] sp;
    cpu = ($urandom_range(99) < cpu1_pct);
    if ($urandom_range(99) < push_pct) begin
      // pooled values give equal watches, so the search order matters
      if ($urandom_range(1) == 1) addr = 32'h0800_0000 | 32'($urandom_range(7));
      else addr = $urandom;
      if ($urandom_range(1) == 1) sp = 32'h2000_0000 + 32'($urandom_range(1)) * 8;
      else sp = $urandom;
      send_push(cpu, 16'($urandom), addr, sp);
    end else if ($urandom_range(99) < 80) begin
      check_known(cpu);
    end else begin
      check_noise(cpu);
    end
  endtask

  // hold off the sender until every result is back
  task automatic drain();
    in_valid <= 1'b0;
    do @(negedge clk); while (pending != 0);
    @(posedge clk);
  endtask

  initial begin
    int n;
    int mode;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // directed: extremes, thumb key forming, middle removal, misses
    send_item(OP_CHECK, 1'b0, 16'h0000, 32'h0000_0000, 32'h0000_0000, 1'b0);
    send_push(1'b0, 16'h0000, 32'h0000_0000, 32'h0000_0000);
    send_push(1'b0, 16'hFFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_push(1'b1, 16'h1234, 32'h0800_1001, 32'h2000_0100);
    send_item(OP_CHECK, 1'b0, 16'hFFFF, 32'hFFFF_FFFE, 32'hFFFF_FFFF, 1'b1);
    send_item(OP_CHECK, 1'b0, 16'h0000, 32'h0000_0000, 32'h0000_0000, 1'b1);
    send_item(OP_CHECK, 1'b0, 16'h0000, 32'h0000_0001, 32'h0000_0000, 1'b0);
    send_push(1'b1, 16'h5678, 32'h0800_1001, 32'h2000_0100);
    send_push(1'b1, 16'h9ABC, 32'h0800_2000, 32'h2000_00F0);
    send_push(1'b0, 16'h0F0F, 32'h0800_1001, 32'h2000_0100);
    send_item(OP_CHECK, 1'b1, 16'h0000, 32'h0800_1000, 32'h2000_0100, 1'b1);
    send_item(OP_CHECK, 1'b1, 16'h0000, 32'h0800_1001, 32'h2000_0104, 1'b1);
    send_item(OP_CHECK, 1'b1, 16'h0000, 32'h0800_1001, 32'h2000_0100, 1'b1);
    send_item(OP_CHECK, 1'b1, 16'h0000, 32'h0800_2001, 32'h2000_00F0, 1'b0);
    send_item(OP_CHECK, 1'b1, 16'h0000, 32'h0800_2000, 32'h2000_00F0, 1'b0);
    send_item(OP_CHECK, 1'b0, 16'h0000, 32'h0800_1000, 32'h2000_0100, 1'b1);
    send_item(OP_CHECK, 1'b0, 16'h0000, 32'h0800_1000, 32'h2000_0100, 1'b1);
    drain();
    shadow[0].delete();
    shadow[1].delete();

    // fill cpu 1 past capacity so the oldest watches get dropped
    for (n = 0; n < WATCHES + 2; n++) random_item(100, 100);
    drain();

    // mixed traffic under each idle and stall pattern
    for (mode = 0; mode < 4; mode++) begin
      case (mode)
        0: begin
          idle_pct  = 0;
          stall_pct = 0;
        end
        1: begin
          idle_pct  = 81;
          stall_pct = 0;
        end
        2: begin
          idle_pct  = 0;
          stall_pct = 81;
        end
        default: begin
          idle_pct  = 24;
          stall_pct = 24;
        end
      endcase
      for (n = 0; n < 50; n++) random_item(50, 60);
      drain();
    end

    repeat (SETTLE) @(posedge clk);
    $display("covered %0d pushes and %0d return checks on both cpus under four idle mixes",
             pushes_sent, checks_sent);
    $display("%0d checks removed a watch, %0d pushes dropped the oldest of a full stack",
             hits, drops);
    if (fails == 0 && pending == 0) begin
      $display("return_watch_stack_unit regression: pass");
    end else begin
      $display("return_watch_stack_unit regression: fail");
    end
    $finish;
  end

endmodule

@@ sim.f @@
+incdir+hdl
hdl/rwsu_pkg.sv
hdl/rwsu_ram.sv
hdl/return_watch_stack_unit.sv
hdl/rwsu_checker.sv
sim/return_watch_stack_checker.sv
sim/tb_return_watch_stack_unit.sv
